### design/fsp_pkg.sv
// ----------------------------------------------------------------------------
// fsp_pkg
// Shared types and constants of the fraction sum parser: widths, ASCII
// codes, result status codes, datapath operations and the controller and
// datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package fsp_pkg;

  localparam int ACC_W  = 32;  // signed width of all running arithmetic
  localparam int CHAR_W = 8;
  localparam int NUM_W  = 32;  // output numerator width
  localparam int DEN_W  = 31;  // output denominator width
  localparam int ST_W   = 2;
  localparam int DIG_W  = 4;
  localparam int OP_W   = 4;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam int                RADIX    = 10;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd1;
  localparam logic [ST_W-1:0] ST_ZDEN = 2'd2;

  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_DIGIT    = 4'd1;
  localparam logic [OP_W-1:0] OP_NEW_TERM = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL1     = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL2     = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL3     = 4'd5;
  localparam logic [OP_W-1:0] OP_FOLD_WB  = 4'd6;
  localparam logic [OP_W-1:0] OP_GCD_INIT = 4'd7;
  localparam logic [OP_W-1:0] OP_GCD_STEP = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_INIT = 4'd9;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd10;
  localparam logic [OP_W-1:0] OP_OUT_LOAD = 4'd11;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [DIG_W-1:0] digit;
    logic             sel_den;
    logic             neg;
    logic [ST_W-1:0]  err;
  } fsp_cmd_t;

  typedef struct packed {
    logic digit_ovf;
    logic term_den_zero;
    logic fold_ovf;
    logic gcd_done;
    logic div_done;
    logic out_busy;
  } fsp_sts_t;

endpackage

`default_nettype wire

### design/fsp_ctrl.sv
// ----------------------------------------------------------------------------
// fsp_ctrl
// Parser and sequencing state machine: decodes characters, tracks the term
// phase and sticky error, and steps the datapath through fold, gcd,
// division and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_ctrl (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  input  wire  [fsp_pkg::CHAR_W-1:0]    in_char,
  input  wire                           in_last,
  input  fsp_pkg::fsp_sts_t             sts,
  output fsp_pkg::fsp_cmd_t             cmd
);
  import fsp_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_FOLD_CHK = 4'd2;
  localparam logic [3:0] S_MUL2     = 4'd3;
  localparam logic [3:0] S_MUL3     = 4'd4;
  localparam logic [3:0] S_FOLD_WB  = 4'd5;
  localparam logic [3:0] S_AFTER    = 4'd6;
  localparam logic [3:0] S_END_CHK  = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;
  localparam logic [3:0] S_GCD      = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_NUM   = 2'd1;
  localparam logic [1:0] PH_DEN   = 2'd2;

  logic [3:0]        state_r, state_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [ST_W-1:0]   err_r, err_nxt;
  logic              end_fold_r, end_fold_nxt;
  logic              new_neg_r, new_neg_nxt;
  logic [1:0]        new_phase_r, new_phase_nxt;
  logic              is_digit;

  assign in_tready = (state_r == S_IDLE);
  assign is_digit  = char_r inside {[CH_0:CH_9]};

  always_comb begin
    state_nxt     = state_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    phase_nxt     = phase_r;
    err_nxt       = err_r;
    end_fold_nxt  = end_fold_r;
    new_neg_nxt   = new_neg_r;
    new_phase_nxt = new_phase_r;
    cmd           = '0;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          char_nxt  = in_char;
          last_nxt  = in_last;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_END_CHK;
        if (is_digit) begin
          if (err_r == ST_OK) begin
            cmd.op      = OP_DIGIT;
            cmd.digit   = DIG_W'(char_r - CH_0);
            cmd.sel_den = (phase_r == PH_DEN);
            if (sts.digit_ovf) err_nxt = ST_OVF;
          end
          if (phase_r != PH_DEN) phase_nxt = PH_NUM;
        end else if (char_r == CH_PLUS || char_r == CH_MINUS) begin
          if (phase_r != PH_START) begin
            new_neg_nxt   = (char_r == CH_MINUS);
            new_phase_nxt = PH_NUM;
            end_fold_nxt  = 1'b0;
            state_nxt     = S_FOLD_CHK;
          end else begin
            cmd.op    = OP_NEW_TERM;
            cmd.neg   = (char_r == CH_MINUS);
            phase_nxt = PH_NUM;
          end
        end else if (char_r == CH_SLASH) begin
          if (phase_r == PH_DEN) begin
            new_neg_nxt   = 1'b0;
            new_phase_nxt = PH_DEN;
            end_fold_nxt  = 1'b0;
            state_nxt     = S_FOLD_CHK;
          end else begin
            phase_nxt = PH_DEN;
          end
        end
      end
      S_FOLD_CHK: begin
        if (err_r != ST_OK) begin
          state_nxt = S_AFTER;
        end else if (sts.term_den_zero) begin
          err_nxt   = ST_ZDEN;
          state_nxt = S_AFTER;
        end else begin
          cmd.op    = OP_MUL1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.op    = OP_MUL2;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.op    = OP_MUL3;
        state_nxt = S_FOLD_WB;
      end
      S_FOLD_WB: begin
        cmd.op = OP_FOLD_WB;
        if (sts.fold_ovf) err_nxt = ST_OVF;
        state_nxt = S_AFTER;
      end
      S_AFTER: begin
        if (end_fold_r) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op    = OP_NEW_TERM;
          cmd.neg   = new_neg_r;
          phase_nxt = new_phase_r;
          state_nxt = S_END_CHK;
        end
      end
      S_END_CHK: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (phase_r != PH_START) begin
          end_fold_nxt = 1'b1;
          state_nxt    = S_FOLD_CHK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (err_r != ST_OK) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_GCD_INIT;
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.op    = OP_DIV_INIT;
          state_nxt = S_DIV;
        end else begin
          cmd.op = OP_GCD_STEP;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_OUT;
        else cmd.op = OP_DIV_STEP;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.op       = OP_OUT_LOAD;
          cmd.err      = err_r;
          err_nxt      = ST_OK;
          phase_nxt    = PH_START;
          end_fold_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_START;
      err_r        <= ST_OK;
      end_fold_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      err_r        <= err_nxt;
      end_fold_r   <= end_fold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    last_r      <= last_nxt;
    new_neg_r   <= new_neg_nxt;
    new_phase_r <= new_phase_nxt;
  end

endmodule

`default_nettype wire

### design/fsp_dp.sv
// ----------------------------------------------------------------------------
// fsp_dp
// Arithmetic datapath: term digit accumulation, running fraction with one
// shared multiplier, binary gcd, two-lane restoring divider and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsp_dp (
  input  wire                         clk,
  input  wire                         rst_n,
  input  fsp_pkg::fsp_cmd_t           cmd,
  output fsp_pkg::fsp_sts_t           sts,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [fsp_pkg::NUM_W-1:0]   out_num,
  output logic [fsp_pkg::DEN_W-1:0]   out_den,
  output logic [fsp_pkg::ST_W-1:0]    out_st
);
  import fsp_pkg::*;

  localparam int W   = ACC_W;
  localparam int PW  = 2 * W;
  localparam int SW  = PW + 2;
  localparam int KW  = $clog2(W);
  localparam int CW  = $clog2(W + 1);
  localparam int EW  = W + 33;
  localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;
  localparam logic [EW-1:0] NUM_POS_LIM = EW'(64'h7FFF_FFFF);
  localparam logic [EW-1:0] NUM_NEG_LIM = EW'(64'h8000_0000);
  localparam logic [EW-1:0] DEN_LIM     = EW'(64'h7FFF_FFFF);

  logic [W-1:0]  acc_num_r, acc_num_nxt;
  logic [W-1:0]  acc_den_r, acc_den_nxt;
  logic [W-1:0]  term_num_r, term_num_nxt;
  logic [W-1:0]  term_den_r, term_den_nxt;
  logic          term_neg_r, term_neg_nxt;
  logic [PW-1:0] p1_r, p2_r, p3_r;
  logic          s1_r, s2_r;
  logic [W-1:0]  x_r, y_r;
  logic [KW-1:0] k_r;
  logic [W-1:0]  dv_r;
  logic [W-1:0]  q_r   [2];
  logic [W-1:0]  rem_r [2];
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  logic [NUM_W-1:0] out_num_r;
  logic [DEN_W-1:0] out_den_r;
  logic [ST_W-1:0]  out_st_r;

  logic [W-1:0]    acc_mag, dig_v, ma, mb;
  logic [W+3:0]    dig_ten;
  logic [PW-1:0]   mul_p;
  logic signed [SW-1:0] v1, v2, vsum;
  logic            rng_bad;
  logic [W:0]      remsh [2];
  logic            ge    [2];
  logic [EW-1:0]   nq_e, dq_e, nneg_e;
  logic            fit;

  assign acc_mag = acc_num_r[W-1] ? (W'(0) - acc_num_r) : acc_num_r;

  // digit accumulation
  assign dig_v   = cmd.sel_den ? term_den_r : term_num_r;
  assign dig_ten = ({4'b0, dig_v} << 3) + ({4'b0, dig_v} << 1) + (W+4)'(cmd.digit);

  // shared multiplier
  always_comb begin
    case (cmd.op)
      OP_MUL1: begin
        ma = acc_mag;
        mb = term_den_r;
      end
      OP_MUL2: begin
        ma = acc_den_r;
        mb = term_num_r;
      end
      default: begin
        ma = acc_den_r;
        mb = term_den_r;
      end
    endcase
  end
  assign mul_p = PW'(ma) * PW'(mb);

  // fold write-back
  assign v1   = s1_r ? (SW'(0) - SW'(p1_r)) : SW'(p1_r);
  assign v2   = s2_r ? (SW'(0) - SW'(p2_r)) : SW'(p2_r);
  assign vsum = v1 + v2;
  assign rng_bad = (v1 > MAXV) || (v1 < MINV) || (v2 > MAXV) || (v2 < MINV) ||
                   (vsum > MAXV) || (vsum < MINV) ||
                   (p3_r > PW'({(W-1){1'b1}}));

  // divider lanes
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      remsh[i] = {rem_r[i], q_r[i][W-1]};
      ge[i]    = (remsh[i] >= {1'b0, dv_r});
    end
  end

  // result fit
  assign nq_e   = EW'(q_r[0]);
  assign dq_e   = EW'(q_r[1]);
  assign nneg_e = EW'(0) - nq_e;
  assign fit    = (acc_num_r[W-1] ? (nq_e <= NUM_NEG_LIM) : (nq_e <= NUM_POS_LIM)) &&
                  (dq_e <= DEN_LIM);

  assign sts.digit_ovf     = (dig_ten > {5'b0, {(W-1){1'b1}}});
  assign sts.term_den_zero = (term_den_r == '0);
  assign sts.fold_ovf      = rng_bad;
  assign sts.gcd_done      = (x_r == '0);
  assign sts.div_done      = (cnt_r == CW'(W));
  assign sts.out_busy      = out_valid_r && !out_ready;

  always_comb begin
    acc_num_nxt  = acc_num_r;
    acc_den_nxt  = acc_den_r;
    term_num_nxt = term_num_r;
    term_den_nxt = term_den_r;
    term_neg_nxt = term_neg_r;
    case (cmd.op)
      OP_DIGIT: begin
        if (!sts.digit_ovf) begin
          if (cmd.sel_den) term_den_nxt = dig_ten[W-1:0];
          else term_num_nxt = dig_ten[W-1:0];
        end
      end
      OP_NEW_TERM: begin
        term_num_nxt = '0;
        term_den_nxt = '0;
        term_neg_nxt = cmd.neg;
      end
      OP_FOLD_WB: begin
        if (!rng_bad) begin
          acc_num_nxt = vsum[W-1:0];
          acc_den_nxt = p3_r[W-1:0];
        end
      end
      OP_OUT_LOAD: begin
        acc_num_nxt  = '0;
        acc_den_nxt  = W'(1);
        term_num_nxt = '0;
        term_den_nxt = '0;
        term_neg_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_num_r   <= '0;
      acc_den_r   <= W'(1);
      term_num_r  <= '0;
      term_den_r  <= '0;
      term_neg_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_num_r  <= acc_num_nxt;
      acc_den_r  <= acc_den_nxt;
      term_num_r <= term_num_nxt;
      term_den_r <= term_den_nxt;
      term_neg_r <= term_neg_nxt;
      if (cmd.op == OP_OUT_LOAD) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL1: begin
        p1_r <= mul_p;
        s1_r <= acc_num_r[W-1];
      end
      OP_MUL2: begin
        p2_r <= mul_p;
        s2_r <= term_neg_r;
      end
      OP_MUL3: begin
        p3_r <= mul_p;
      end
      OP_GCD_INIT: begin
        x_r <= acc_mag;
        y_r <= acc_den_r;
        k_r <= '0;
      end
      OP_GCD_STEP: begin
        if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + KW'(1);
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
      OP_DIV_INIT: begin
        dv_r     <= y_r << k_r;
        q_r[0]   <= acc_mag;
        q_r[1]   <= acc_den_r;
        rem_r[0] <= '0;
        rem_r[1] <= '0;
        cnt_r    <= '0;
      end
      OP_DIV_STEP: begin
        for (int i = 0; i < 2; i++) begin
          rem_r[i] <= ge[i] ? W'(remsh[i] - {1'b0, dv_r}) : remsh[i][W-1:0];
          q_r[i]   <= {q_r[i][W-2:0], ge[i]};
        end
        cnt_r <= cnt_r + CW'(1);
      end
      OP_OUT_LOAD: begin
        if (cmd.err != ST_OK) begin
          out_num_r <= '0;
          out_den_r <= '0;
          out_st_r  <= cmd.err;
        end else if (fit) begin
          out_num_r <= acc_num_r[W-1] ? nneg_e[NUM_W-1:0] : nq_e[NUM_W-1:0];
          out_den_r <= dq_e[DEN_W-1:0];
          out_st_r  <= ST_OK;
        end else begin
          out_num_r <= '0;
          out_den_r <= '0;
          out_st_r  <= ST_OVF;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_num   = out_num_r;
  assign out_den   = out_den_r;
  assign out_st    = out_st_r;

endmodule

`default_nettype wire

### design/fraction_sum_parser_core.sv
// ----------------------------------------------------------------------------
// fraction_sum_parser_core
// Adds a signed sum of ASCII fractions such as -1/2+3/4 taken one character
// per transaction, and returns the reduced sum when the last character of
// an expression arrives.
//
//   channel | dir | tdata                         | tuser      | tlast
//   in_     | in  | [7:0] char_code               | -          | last
//   out_    | out | [31:0] num, [62:32] den, pad  | [1:0] stat | -
//
// A plain character is decoded and checked for the expression end; one
// that ends a term is also folded in through the single shared multiplier.
// At expression end: binary gcd (one step per cycle), then a restoring
// division of 32 steps and a done check, then the result load once the
// result register is free.
// in_tready is high only in the idle state; the result register lets the
// next expression start while a result is still waiting on out_tready.
// Synchronous active-low reset leaves the running sum at 0/1.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_sum_parser_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] char_code
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // [31:0] sum_numerator, [62:32] sum_denominator, [63] 0
  output logic [1:0]  out_tuser   // [1:0] status
);
  import fsp_pkg::*;

  fsp_cmd_t         cmd;
  fsp_sts_t         sts;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;

  fsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  fsp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_num   (num),
    .out_den   (den),
    .out_st    (out_tuser)
  );

  assign out_tdata = {1'b0, den, num};

endmodule

`default_nettype wire

### dv/fraction_sum_parser_core_tb.sv
// ----------------------------------------------------------------------------
// fraction_sum_parser_core_tb
// Streams ASCII fraction expressions into the parser one character per
// transaction and checks every reduced sum. An in-bench tracker parses the
// same characters and queues the sum and status for each expression end.
// Directed cases cover sign handling, ignored characters, an empty
// expression, a slash after a denominator, a zero denominator and digit
// overflow. The random part follows with random stalls on both sides and a
// long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_sum_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsp_pkg::*;

  localparam int     CYCLE_LIMIT = 1_500_000;
  localparam int     DRAIN_WAIT  = 300;
  localparam longint POS_MAX     = 64'sd2147483647;
  localparam longint NEG_MIN     = -64'sd2147483648;

  typedef enum logic [1:0] {PH_START, PH_NUM, PH_DEN} phase_t;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic [ST_W-1:0]  stat;
  } frac_sum_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  // tracker state
  longint          run_num = 0;
  longint          run_den = 1;
  longint          term_num = 0;
  longint          term_den = 0;
  bit              term_neg = 1'b0;
  phase_t          phase = PH_START;
  logic [ST_W-1:0] sticky_err = ST_OK;
  frac_sum_t       pending_sums[$];

  bit    idle_on = 1'b1;
  int    hold_left = 0;
  int    stall_left = 0;
  int    errors = 0;
  int    cycles = 0;
  int    n_chars = 0;
  int    n_exprs = 0;
  int    n_ok = 0;
  int    n_ovf = 0;
  int    n_zden = 0;
  string fmt_chars = "0123456789+-/ ";

  fraction_sum_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic bit fits_acc(input longint v);
    return (v >= NEG_MIN) && (v <= POS_MAX);
  endfunction

  function automatic longint push_digit(input longint v, input int d);
    if (sticky_err != ST_OK) return v;
    if (v * 10 + d > POS_MAX) begin
      sticky_err = ST_OVF;
      return v;
    end
    return v * 10 + d;
  endfunction

  function automatic void start_term(input bit neg, input phase_t ph);
    term_num = 0;
    term_den = 0;
    term_neg = neg;
    phase    = ph;
  endfunction

  function automatic void fold_term();
    longint p1, p2, s, nd, n;
    if (sticky_err != ST_OK) return;
    if (term_den == 0) begin
      sticky_err = ST_ZDEN;
      return;
    end
    n  = term_neg ? -term_num : term_num;
    p1 = run_num * term_den;
    p2 = run_den * n;
    s  = p1 + p2;
    nd = run_den * term_den;
    if (!fits_acc(p1) || !fits_acc(p2) || !fits_acc(s) || nd > POS_MAX) begin
      sticky_err = ST_OVF;
    end else begin
      run_num = s;
      run_den = nd;
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input logic l);
    frac_sum_t r;
    longint    x, y, t, nm, dn;
    n_chars++;
    if (c >= CH_0 && c <= CH_9) begin
      if (phase == PH_DEN) begin
        term_den = push_digit(term_den, int'(c - CH_0));
      end else begin
        term_num = push_digit(term_num, int'(c - CH_0));
        phase    = PH_NUM;
      end
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      if (phase != PH_START) fold_term();
      start_term(c == CH_MINUS, PH_NUM);
    end else if (c == CH_SLASH) begin
      if (phase == PH_DEN) begin
        fold_term();
        start_term(1'b0, PH_DEN);
      end else begin
        phase = PH_DEN;
      end
    end
    if (!l) return;

    if (phase != PH_START) fold_term();
    r.num  = '0;
    r.den  = '0;
    r.stat = sticky_err;
    if (sticky_err == ST_OK) begin
      x = (run_num < 0) ? -run_num : run_num;
      y = run_den;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      nm = run_num / x;
      dn = run_den / x;
      if (!fits_acc(nm) || dn > POS_MAX) begin
        r.stat = ST_OVF;
      end else begin
        r.num = nm[NUM_W-1:0];
        r.den = dn[DEN_W-1:0];
      end
    end
    pending_sums = {pending_sums, r};
    n_exprs++;
    if (r.stat == ST_OK) n_ok++;
    else if (r.stat == ST_OVF) n_ovf++;
    else n_zden++;

    run_num    = 0;
    run_den    = 1;
    sticky_err = ST_OK;
    start_term(1'b0, PH_START);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_char(input logic [7:0] c, input logic l);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    parse_char(c, l);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], ends && (i == s.len() - 1));
    end
  endtask

  task automatic send_random_expression();
    logic [7:0] text[$];
    int         kind, terms, nd;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      repeat ($urandom_range(1, 10)) begin
        if (kind == 8) text = {text, 8'($urandom_range(0, 255))};
        else text = {text, 8'(fmt_chars[$urandom_range(0, fmt_chars.len() - 1)])};
      end
    end else begin
      terms = $urandom_range(1, 4);
      for (int t = 0; t < terms; t++) begin
        if (t > 0 || $urandom_range(0, 1))
          text = {text, ($urandom_range(0, 1) ? CH_MINUS : CH_PLUS)};
        if (kind == 7 && $urandom_range(0, 1)) nd = $urandom_range(8, 11);
        else if (kind == 6) nd = $urandom_range(0, 3);
        else nd = $urandom_range(1, 3);
        if (kind == 7 && nd >= 10) text = {text, 8'(CH_0 + $urandom_range(1, 2))};
        else if (nd > 0) text = {text, 8'(CH_0 + $urandom_range(0, 9))};
        repeat (nd - 1) text = {text, 8'(CH_0 + $urandom_range(0, 9))};
        if ($urandom_range(0, 15) == 0) text = {text, 8'($urandom_range(128, 255))};
        if (!(kind == 6 && $urandom_range(0, 2) == 0)) begin
          text = {text, CH_SLASH};
          text = {text,
                  8'(CH_0 + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 9)))};
          nd = (kind == 7 && $urandom_range(0, 1)) ? $urandom_range(4, 9) : $urandom_range(0, 1);
          repeat (nd) text = {text, 8'(CH_0 + $urandom_range(0, 9))};
        end
      end
    end
    for (int i = 0; i < text.size(); i++) begin
      push_char(text[i], i == text.size() - 1);
    end
  endtask

  task automatic test_sign_and_fold();
    send_text("-1/2+3/4", 1'b1);
  endtask

  task automatic test_ignored_and_empty();
    push_char(8'hFF, 1'b1);
    send_text("1/3", 1'b0);
    push_char(8'h00, 1'b0);
    send_text("/6", 1'b1);
  endtask

  task automatic test_zero_denominator();
    send_text("5/", 1'b1);
  endtask

  task automatic test_digit_overflow();
    send_text("9999999999", 1'b1);
  endtask

  task automatic test_output_hold();
    hold_left = 3000;
    repeat (6) send_random_expression();
  endtask

  task automatic test_random_expressions(input int char_count);
    int stop_at;
    stop_at = n_chars + char_count;
    while (n_chars < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      send_random_expression();
    end
  endtask

  task automatic test_steady_stream(input int char_count);
    int stop_at;
    stop_at = n_chars + char_count;
    idle_on = 1'b0;
    while (n_chars < stop_at) send_random_expression();
  endtask

  // output ready: random stalls plus an occasional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frac_sum_t exp_sum;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result transaction: num %0d den %0d status %0d",
               $signed(out_tdata[31:0]), out_tdata[62:32], out_tuser);
        errors++;
      end else begin
        exp_sum = pending_sums.pop_front();
        if (out_tdata[31:0] !== exp_sum.num) begin
          $error("sum_numerator: expected %0d, got %0d",
                 $signed(exp_sum.num), $signed(out_tdata[31:0]));
          errors++;
        end
        if (out_tdata[62:32] !== exp_sum.den) begin
          $error("sum_denominator: expected %0d, got %0d", exp_sum.den, out_tdata[62:32]);
          errors++;
        end
        if (out_tuser !== exp_sum.stat) begin
          $error("status: expected %0d, got %0d", exp_sum.stat, out_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d sums outstanding", cycles, pending_sums.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_sign_and_fold();
    test_ignored_and_empty();
    test_zero_denominator();
    test_digit_overflow();
    test_output_hold();
    test_random_expressions(1050);
    test_steady_stream(150);

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    idle_on   = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Parsed %0d characters forming %0d expressions in %0d cycles.",
             n_chars, n_exprs, cycles);
    $display("Sums: %0d valid, %0d overflow, %0d zero denominator.", n_ok, n_ovf, n_zden);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/fsp_pkg.sv
design/fsp_ctrl.sv
design/fsp_dp.sv
design/fraction_sum_parser_core.sv
dv/fraction_sum_parser_core_tb.sv
